>>> rtl/core/alief_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alief_pkg;

    // Store geometry and field widths
    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned MAX_RESULTS  = 16;
    localparam int unsigned ACTION_W     = 4;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned FPOS_W       = 4;
    localparam int unsigned ECNT_W       = 5;

    // Action codes on s_action
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT_AT  = 4'd0,
        ACT_ERASE_AT   = 4'd1,
        ACT_FIND       = 4'd2,
        ACT_PUSH_FRONT = 4'd3,
        ACT_PUSH_BACK  = 4'd4,
        ACT_POP_FRONT  = 4'd5,
        ACT_POP_BACK   = 4'd6,
        ACT_DUMP       = 4'd7,
        ACT_CLEAR      = 4'd8
    } action_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_FIND,
        S_DUMP_RD,
        S_DUMP_EM,
        S_EMIT
    } ctrl_state_t;

    // Source of the latched list position
    typedef enum logic [1:0] {
        POS_IN,
        POS_ZERO,
        POS_CNT
    } pos_sel_t;

    // Walk index update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_POS,
        IDX_CNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    // Store read request
    typedef enum logic [2:0] {
        RD_NONE,
        RD_MOVE_UP,
        RD_MOVE_DN,
        RD_FIND,
        RD_DUMP
    } rd_op_t;

    // Entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        pos_sel_t pos_sel;
        idx_op_t  idx_op;
        rd_op_t   rd_op;
        logic     put;
        cnt_op_t  cnt_op;
        logic     emit;
        status_t  emit_status;
        logic     emit_found;
        logic     emit_data;
        logic     emit_last;
    } alief_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic in_pos_gt_cnt;
        logic in_pos_ge_cnt;
        logic idx_gt_pos;
        logic idx_lt_last;
        logic idx_lt_cnt;
        logic dump_last;
        logic cmp_pend;
        logic hit;
        logic out_free;
    } alief_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/alief_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module alief_dpath
    import alief_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  alief_cmd_t                 cmd,
    output alief_stat_t                stat,
    input  logic [POS_W-1:0]           s_position,
    input  logic signed [VALUE_W-1:0]  s_value_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic                       m_found,
    output logic [FPOS_W-1:0]          m_found_position,
    output logic signed [VALUE_W-1:0]  m_value_out,
    output logic [ECNT_W-1:0]          m_entry_count,
    output logic                       m_last
);

    localparam int unsigned IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned MRW = $clog2(MAX_RESULTS + 1);
    localparam int unsigned CW0 = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned XW  = ((CW0 > MRW) ? CW0 : MRW) + 1;

    // List store
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      pos_reg, pos_next, pos_new;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               mv_pend_reg, mv_pend_next;
    logic [IW-1:0]      mv_dst_reg, mv_dst_next;
    logic               cmp_pend_reg, cmp_pend_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;

    logic               rd_en;
    logic [CW-1:0]      rd_idx;
    logic [IW-1:0]      rd_addr;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic                m_found_reg, m_found_next;
    logic [FPOS_W-1:0]   m_fpos_reg, m_fpos_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic [ECNT_W-1:0]   m_ecnt_reg, m_ecnt_next;
    logic                m_last_reg, m_last_next;

    logic [XW-1:0] cnt_x, posr_x, pos_in_x, idx_x, mr_x, cap_x, dump_n_x;

    // Widened operands for compares
    assign cnt_x    = XW'(count_reg);
    assign posr_x   = XW'(pos_reg);
    assign pos_in_x = XW'(s_position);
    assign idx_x    = XW'(idx_reg);
    assign mr_x     = XW'(MAX_RESULTS);
    assign cap_x    = XW'(CAPACITY);
    assign dump_n_x = (cnt_x > mr_x) ? mr_x : cnt_x;

    // Status to controller
    always_comb begin
        stat.count_zero    = (count_reg == '0);
        stat.count_full    = (cnt_x == cap_x);
        stat.in_pos_gt_cnt = (pos_in_x > cnt_x);
        stat.in_pos_ge_cnt = (pos_in_x >= cnt_x);
        stat.idx_gt_pos    = (idx_x > posr_x);
        stat.idx_lt_last   = ((idx_x + XW'(1)) < cnt_x);
        stat.idx_lt_cnt    = (idx_x < cnt_x);
        stat.dump_last     = ((idx_x + XW'(1)) == dump_n_x);
        stat.cmp_pend      = cmp_pend_reg;
        stat.hit           = cmp_pend_reg && (rdata_reg == key_reg);
        stat.out_free      = !m_valid_reg || m_ready;
    end

    // Operand latch at transaction accept
    always_comb begin
        unique case (cmd.pos_sel)
            POS_IN:   pos_new = IW'(s_position);
            POS_ZERO: pos_new = '0;
            POS_CNT:  pos_new = IW'(count_reg);
            default:  pos_new = '0;
        endcase
        pos_next = cmd.accept ? pos_new : pos_reg;
        key_next = cmd.accept ? $unsigned(s_value_in) : key_reg;
    end

    // Walk index
    always_comb begin
        unique case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_ZERO: idx_next = '0;
            IDX_POS:  idx_next = CW'(pos_new);
            IDX_CNT:  idx_next = count_reg;
            IDX_INC:  idx_next = CW'(idx_reg + 1'b1);
            IDX_DEC:  idx_next = CW'(idx_reg - 1'b1);
            default:  idx_next = idx_reg;
        endcase
    end

    // Entry count
    always_comb begin
        unique case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = CW'(count_reg + 1'b1);
            CNT_DEC:  count_next = CW'(count_reg - 1'b1);
            CNT_CLR:  count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    // Read address; a move writes its data in the cycle after the read
    always_comb begin
        rd_en  = 1'b1;
        rd_idx = idx_reg;
        unique case (cmd.rd_op)
            RD_NONE:    rd_en = 1'b0;
            RD_MOVE_UP: rd_idx = CW'(idx_reg - 1'b1);
            RD_MOVE_DN: rd_idx = CW'(idx_reg + 1'b1);
            RD_FIND:    rd_idx = idx_reg;
            RD_DUMP:    rd_idx = idx_reg;
            default:    rd_en = 1'b0;
        endcase
        rd_addr = rd_idx[IW-1:0];

        mv_pend_next  = (cmd.rd_op == RD_MOVE_UP) || (cmd.rd_op == RD_MOVE_DN);
        mv_dst_next   = mv_pend_next ? idx_reg[IW-1:0] : mv_dst_reg;
        cmp_pend_next = (cmd.rd_op == RD_FIND);
        cmp_idx_next  = cmp_pend_next ? rd_addr : cmp_idx_reg;
    end

    // Write port: pending move, or the new value
    assign mem_we    = mv_pend_reg || cmd.put;
    assign mem_waddr = mv_pend_reg ? mv_dst_reg : pos_reg;
    assign mem_wdata = mv_pend_reg ? rdata_reg : key_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Result register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_fpos_next   = m_fpos_reg;
        m_value_next  = m_value_reg;
        m_ecnt_next   = m_ecnt_reg;
        m_last_next   = m_last_reg;
        if (cmd.emit) begin
            m_valid_next  = 1'b1;
            m_status_next = cmd.emit_status;
            m_found_next  = cmd.emit_found;
            m_fpos_next   = cmd.emit_found ? FPOS_W'(cmp_idx_reg) : '0;
            m_value_next  = cmd.emit_data ? rdata_reg : '0;
            m_ecnt_next   = ECNT_W'(count_reg);
            m_last_next   = cmd.emit_last;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            mv_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            mv_pend_reg  <= mv_pend_next;
            cmp_pend_reg <= cmp_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        mv_dst_reg   <= mv_dst_next;
        cmp_idx_reg  <= cmp_idx_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_fpos_reg   <= m_fpos_next;
        m_value_reg  <= m_value_next;
        m_ecnt_reg   <= m_ecnt_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found          = m_found_reg;
    assign m_found_position = m_fpos_reg;
    assign m_value_out      = $signed(m_value_reg);
    assign m_entry_count    = m_ecnt_reg;
    assign m_last           = m_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/alief_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module alief_ctrl
    import alief_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [ACTION_W-1:0] s_action,
    output logic                s_ready,
    input  alief_stat_t         stat,
    output alief_cmd_t          cmd
);

    ctrl_state_t state_reg, state_next;
    status_t     res_status_reg, res_status_next;
    logic        res_found_reg, res_found_next;
    action_t     act;

    assign act = action_t'(s_action);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (act)
                        ACT_INSERT_AT:
                            state_next = (stat.in_pos_gt_cnt || stat.count_full) ?
                                         S_EMIT : S_SHIFT_UP;
                        ACT_ERASE_AT:
                            state_next = (stat.count_zero || stat.in_pos_ge_cnt) ?
                                         S_EMIT : S_SHIFT_DN;
                        ACT_FIND:
                            state_next = S_FIND;
                        ACT_PUSH_FRONT, ACT_PUSH_BACK:
                            state_next = stat.count_full ? S_EMIT : S_SHIFT_UP;
                        ACT_POP_FRONT:
                            state_next = stat.count_zero ? S_EMIT : S_SHIFT_DN;
                        ACT_DUMP:
                            state_next = stat.count_zero ? S_EMIT : S_DUMP_RD;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_SHIFT_UP: begin
                if (!stat.idx_gt_pos) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: state_next = S_EMIT;
            S_SHIFT_DN: begin
                if (!stat.idx_lt_last) begin
                    state_next = S_EMIT;
                end
            end
            S_FIND: begin
                if (stat.hit || (!stat.idx_lt_cnt && !stat.cmp_pend)) begin
                    state_next = S_EMIT;
                end
            end
            S_DUMP_RD: state_next = S_DUMP_EM;
            S_DUMP_EM: begin
                if (stat.out_free) begin
                    state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.pos_sel     = POS_IN;
        cmd.idx_op      = IDX_HOLD;
        cmd.rd_op       = RD_NONE;
        cmd.cnt_op      = CNT_HOLD;
        cmd.emit_status = ST_OK;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept      = 1'b1;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    unique case (act)
                        ACT_INSERT_AT: begin
                            if (stat.in_pos_gt_cnt) begin
                                res_status_next = ST_BADPOS;
                            end else if (stat.count_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                cmd.idx_op = IDX_CNT;
                            end
                        end
                        ACT_ERASE_AT: begin
                            if (stat.count_zero) begin
                                res_status_next = ST_EMPTY;
                            end else if (stat.in_pos_ge_cnt) begin
                                res_status_next = ST_BADPOS;
                            end else begin
                                cmd.idx_op = IDX_POS;
                            end
                        end
                        ACT_FIND: cmd.idx_op = IDX_ZERO;
                        ACT_PUSH_FRONT: begin
                            cmd.pos_sel = POS_ZERO;
                            if (stat.count_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                cmd.idx_op = IDX_CNT;
                            end
                        end
                        ACT_PUSH_BACK: begin
                            cmd.pos_sel = POS_CNT;
                            if (stat.count_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                cmd.idx_op = IDX_CNT;
                            end
                        end
                        ACT_POP_FRONT: begin
                            cmd.pos_sel = POS_ZERO;
                            if (stat.count_zero) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                cmd.idx_op = IDX_POS;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (stat.count_zero) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                cmd.cnt_op = CNT_DEC;
                            end
                        end
                        ACT_DUMP:  cmd.idx_op = IDX_ZERO;
                        ACT_CLEAR: cmd.cnt_op = CNT_CLR;
                        default: ;
                    endcase
                end
            end
            // Move entries up one slot, from the tail down to the insert position
            S_SHIFT_UP: begin
                if (stat.idx_gt_pos) begin
                    cmd.rd_op  = RD_MOVE_UP;
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                cmd.cnt_op = CNT_INC;
            end
            // Move entries down one slot, from the erase position to the tail
            S_SHIFT_DN: begin
                if (stat.idx_lt_last) begin
                    cmd.rd_op  = RD_MOVE_DN;
                    cmd.idx_op = IDX_INC;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_FIND: begin
                if (stat.hit) begin
                    res_found_next = 1'b1;
                end else if (stat.idx_lt_cnt) begin
                    cmd.rd_op  = RD_FIND;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DUMP_RD: cmd.rd_op = RD_DUMP;
            S_DUMP_EM: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.emit_last = stat.dump_last;
                    if (!stat.dump_last) begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = res_status_reg;
                    cmd.emit_found  = res_found_reg;
                    cmd.emit_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/array_list_insert_erase_find_unit.sv
// Ordered list of signed 32-bit entries in a single-port-write, single-port-read store.
// One transaction in flight: insert or push shifts the tail up a slot and writes the value,
// erase or pop_front shifts the tail down over the position, find reads until a hit, dump
// reads and emits each entry in turn; shifts and find move or read one entry per cycle.
// A new transaction is taken while the last result still waits in the output register.
// Synchronous active-low reset empties the list; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_list_insert_erase_find_unit
    import alief_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ACTION_W-1:0]        s_action,
    input  logic [POS_W-1:0]           s_position,
    input  logic signed [VALUE_W-1:0]  s_value_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic                       m_found,
    output logic [FPOS_W-1:0]          m_found_position,
    output logic signed [VALUE_W-1:0]  m_value_out,
    output logic [ECNT_W-1:0]          m_entry_count,
    output logic                       m_last
);

    alief_cmd_t  cmd;
    alief_stat_t stat;

    alief_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    alief_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_position       (s_position),
        .s_value_in       (s_value_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found          (m_found),
        .m_found_position (m_found_position),
        .m_value_out      (m_value_out),
        .m_entry_count    (m_entry_count),
        .m_last           (m_last)
    );

    // One transaction at a time: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction was in progress");

    // Count reported never exceeds the store size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((CAPACITY > 31) || (32'(m_entry_count) <= CAPACITY)))
        else $error("entry count above capacity");

    // A find hit is a single clean result
    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_status == ST_OK && m_last && m_value_out == 0))
        else $error("found result malformed");

    // A failed action is a single result with no data
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_last && !m_found && m_value_out == 0))
        else $error("error result malformed");

endmodule

`default_nettype wire
